[hdl/glob_wildcard_matcher_core_assert.svh]
// Assertion macros shared by the glob matcher checker.
// No dependencies; include by bare file name.
`ifndef GLOB_WILDCARD_MATCHER_CORE_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define GWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gwm_pkg.sv]
// Shared types and constants for the glob wildcard matcher.
// No dependencies; compiled before every other file.
package gwm_pkg;

    localparam int PATTERN_CAPACITY_DEF = 32;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

    typedef struct packed {
        logic       restart;
        logic       clear;
        logic       append;
        logic [7:0] symbol;
    } t_cell_ctl;

endpackage

[hdl/gwm_chan_if.sv]
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is supplied by the instantiating level (see gwm_pkg).
interface gwm_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/gwm_cell.sv]
// One pattern position: stored character and active bit.
// Depends on gwm_pkg; chained by glob_wildcard_matcher_core.
module gwm_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  gwm_pkg::t_cell_ctl  i_ctl,
    input  logic [LEN_W-1:0]    i_length,
    input  logic                i_fwd,
    output logic                o_fwd,
    output logic                o_tail
);
    import gwm_pkg::*;

    logic [7:0] r_char;
    logic       r_act;
    logic       n_act;
    logic       w_wr;
    logic       w_in_len;
    logic       w_valid;
    logic [7:0] w_char;
    logic       w_star;
    logic       w_match;

    assign w_in_len = (LEN_W'(INDEX) < i_length);
    assign w_wr     = i_ctl.append && (i_length == LEN_W'(INDEX));
    assign w_valid  = !i_ctl.clear && (w_in_len || w_wr);
    assign w_char   = w_wr ? i_ctl.symbol : r_char;
    assign w_star   = (w_char == CH_STAR);
    assign w_match  = (w_char == i_ctl.symbol) ||
                      ((w_char == CH_ANY) && (i_ctl.symbol != CH_DOT));

    always_comb begin
        if (i_ctl.restart) begin
            n_act = i_fwd;
            o_fwd = w_valid && w_star && n_act;
        end else begin
            n_act = (r_act && w_star && w_valid) || i_fwd;
            o_fwd = w_valid && (w_star ? n_act : (r_act && w_match));
        end
    end

    assign o_tail = r_act && !w_in_len;

    always_ff @(posedge i_clk) begin
        if (i_accept && w_wr) begin
            r_char <= i_ctl.symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= (INDEX == 0);
        end else if (i_accept) begin
            r_act <= n_act;
        end
    end

endmodule

[hdl/glob_wildcard_matcher_core.sv]
// Glob wildcard matcher top level: command decode, chain of position cells,
// pattern length, overflow flag and result register. Depends on gwm_pkg,
// gwm_chan_if and gwm_cell.
//
//   channel  dir  payload                          transaction
//   i_in     in   cmd[1:0], symbol[7:0]            valid & ready
//   o_out    out  matched, pattern_overflow        valid & ready (END only)
//
// One transaction per cycle on i_in while i_in.ready is high; every command is one transaction.
// The active set settles in a single ripple through the cell chain
// (PATTERN_CAPACITY cells), which sets the clock period.
// An END result appears in the output register the cycle after acceptance.
// i_in.ready drops only while a result is held and o_out.ready is low.
// Synchronous reset leaves an empty pattern and no pending result.
module glob_wildcard_matcher_core #(
    parameter int PATTERN_CAPACITY = gwm_pkg::PATTERN_CAPACITY_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    gwm_chan_if.sink   i_in,
    gwm_chan_if.source o_out
);
    import gwm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_CAPACITY + 1);

    t_cell_ctl                 w_ctl;
    logic                      w_accept;
    logic [PATTERN_CAPACITY:0] w_fwd;
    logic [PATTERN_CAPACITY-1:0] w_tail;
    logic [LEN_W-1:0]          r_length;
    logic                      r_overflow;
    logic                      r_act_last;
    logic                      r_out_valid;
    t_out_item                 r_out;
    logic                      w_full;
    logic                      w_hit;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_ctl.restart = (i_in.data.cmd != CMD_SUBJECT);
    assign w_ctl.clear   = (i_in.data.cmd == CMD_CLEAR);
    assign w_ctl.append  = (i_in.data.cmd == CMD_APPEND);
    assign w_ctl.symbol  = i_in.data.symbol;

    assign w_fwd[0] = w_ctl.restart;

    for (genvar g = 0; g < PATTERN_CAPACITY; g++) begin : g_cell
        gwm_cell #(
            .INDEX (g),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_ctl    (w_ctl),
            .i_length (r_length),
            .i_fwd    (w_fwd[g]),
            .o_fwd    (w_fwd[g+1]),
            .o_tail   (w_tail[g])
        );
    end

    assign w_full = (r_length == LEN_W'(PATTERN_CAPACITY));
    assign w_hit  = ((|w_tail) || r_act_last) && !r_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length   <= '0;
            r_overflow <= 1'b0;
            r_act_last <= 1'b0;
        end else if (w_accept) begin
            r_act_last <= w_fwd[PATTERN_CAPACITY];
            if (w_ctl.clear) begin
                r_length   <= '0;
                r_overflow <= 1'b0;
            end else if (w_ctl.append) begin
                if (w_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_length <= r_length + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && (i_in.data.cmd == CMD_END)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.data.cmd == CMD_END)) begin
            r_out.matched          <= w_hit;
            r_out.pattern_overflow <= r_overflow;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[hdl/gwm_checker.sv]
// Port-level assertions for glob_wildcard_matcher_core, attached by bind.
// Depends on gwm_pkg and glob_wildcard_matcher_core_assert.svh.
`include "glob_wildcard_matcher_core_assert.svh"

module gwm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_matched,
    input logic       i_out_overflow
);
    import gwm_pkg::*;

    logic w_end_acc;

    assign w_end_acc = i_in_valid && i_in_ready && (i_in_cmd == CMD_END);

    `GWM_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, w_end_acc, i_out_valid, "END transaction produced no result")
    `GWM_ASSERT_NOW(a_result_from_end, i_clk, i_rst_n, $rose(i_out_valid), $past(w_end_acc), "result appeared without END transaction")
    `GWM_ASSERT_NOW(a_no_match_on_overflow, i_clk, i_rst_n, i_out_valid, !(i_out_matched && i_out_overflow), "match reported with pattern overflow")
    `GWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `GWM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output register")

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.data.cmd),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_matched  (o_out.data.matched),
    .i_out_overflow (o_out.data.pattern_overflow)
);

[dv/glob_wildcard_matcher_core_tb.sv]
// Self-checking testbench for glob_wildcard_matcher_core: directed and random
// command streams, verdicts checked against an in-bench matcher model.
// Depends on gwm_pkg, gwm_chan_if and the core RTL.
module glob_wildcard_matcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int CAP = PATTERN_CAPACITY_DEF;

    logic i_clk;
    logic i_rst_n;

    gwm_chan_if #(.T(t_in_item))  in_if ();
    gwm_chan_if #(.T(t_out_item)) out_if ();

    glob_wildcard_matcher_core #(
        .PATTERN_CAPACITY(CAP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [7:0]   pat_mem [CAP];
    logic [5:0]   pat_len;
    logic [CAP:0] live_pos;
    logic         pat_ovf;
    t_out_item    verdict_q[$];

    int err_count     = 0;
    int sent_count    = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [CAP:0] close_over_stars(input logic [CAP:0] s);
        for (int p = 0; p < pat_len; p++) begin
            if (s[p] && pat_mem[p] == CH_STAR) s[p+1] = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [CAP:0] fresh_subject();
        logic [CAP:0] s;
        s    = '0;
        s[0] = 1'b1;
        return close_over_stars(s);
    endfunction

    function automatic logic [CAP:0] consume_char(input logic [7:0] c);
        logic [CAP:0] nxt;
        nxt = '0;
        for (int p = 0; p < pat_len; p++) begin
            if (live_pos[p]) begin
                if (pat_mem[p] == CH_STAR) nxt[p] = 1'b1;
                else if (pat_mem[p] == c || (pat_mem[p] == CH_ANY && c != CH_DOT))
                    nxt[p+1] = 1'b1;
            end
        end
        return close_over_stars(nxt);
    endfunction

    function automatic void advance_matcher(input t_cmd op, input logic [7:0] sym);
        t_out_item v;
        case (op)
            CMD_CLEAR: begin
                pat_len  = '0;
                pat_ovf  = 1'b0;
                live_pos = fresh_subject();
            end
            CMD_APPEND: begin
                if (pat_len < CAP) begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                live_pos = fresh_subject();
            end
            CMD_SUBJECT: begin
                live_pos = consume_char(sym);
            end
            default: begin
                v.matched          = live_pos[pat_len] && !pat_ovf;
                v.pattern_overflow = pat_ovf;
                verdict_q.push_back(v);
                live_pos = fresh_subject();
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_verdict(input t_out_item got);
        t_out_item want;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("result %b with none pending", got));
        end else begin
            want = verdict_q.pop_front();
            if (got.matched !== want.matched)
                report_mismatch($sformatf("matched: expected %b got %b",
                                          want.matched, got.matched));
            if (got.pattern_overflow !== want.pattern_overflow)
                report_mismatch($sformatf("pattern_overflow: expected %b got %b",
                                          want.pattern_overflow, got.pattern_overflow));
        end
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        if (i_rst_n && out_if.valid && out_if.ready) check_verdict(out_if.data);
    end

    task automatic send_item(input t_cmd op, input logic [7:0] sym);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data.cmd    <= op;
        in_if.data.symbol <= sym;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        advance_matcher(op, sym);
        sent_count++;
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0:          return CH_STAR;
            1:          return CH_ANY;
            2:          return CH_DOT;
            3, 4, 5, 6: return 8'h61 + 8'($urandom_range(2));
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_noise();
        send_item(t_cmd'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    task automatic test_empty_pattern();
        send_item(CMD_END, 8'h00);
        send_item(CMD_SUBJECT, 8'h61);
        send_item(CMD_END, 8'hFF);
    endtask

    task automatic test_literal_symbols();
        send_item(CMD_CLEAR, 8'hFF);
        send_item(CMD_APPEND, 8'h00);
        send_item(CMD_APPEND, 8'hFF);
        send_item(CMD_APPEND, CH_DOT);
        send_item(CMD_SUBJECT, 8'h00);
        send_item(CMD_SUBJECT, 8'hFF);
        send_item(CMD_SUBJECT, CH_DOT);
        send_item(CMD_END, 8'h00);
        send_item(CMD_SUBJECT, 8'h00);
        send_item(CMD_END, 8'h00);
    endtask

    task automatic test_wildcards();
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_APPEND, CH_STAR);
        send_item(CMD_APPEND, CH_STAR);
        send_item(CMD_END, 8'h00);
        send_item(CMD_APPEND, CH_ANY);
        send_item(CMD_SUBJECT, CH_DOT);
        send_item(CMD_END, 8'h00);
        send_item(CMD_SUBJECT, 8'h71);
        send_item(CMD_SUBJECT, 8'h71);
        send_item(CMD_END, 8'h00);
    endtask

    task automatic test_restart_mid_subject();
        send_item(CMD_SUBJECT, 8'h61);
        send_item(CMD_APPEND, 8'h62);
        send_item(CMD_END, 8'h00);
        send_item(CMD_SUBJECT, 8'h61);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_END, 8'h00);
    endtask

    task automatic test_pattern_overflow();
        send_item(CMD_CLEAR, 8'h00);
        repeat (CAP + 1) send_item(CMD_APPEND, CH_STAR);
        send_item(CMD_END, 8'h00);
        send_item(CMD_SUBJECT, 8'h61);
        send_item(CMD_END, 8'h00);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_END, 8'h00);
    endtask

    task automatic run_sequence();
        int         n_pat;
        logic [7:0] subj[$];
        logic [7:0] c;
        if ($urandom_range(4) != 0) send_item(CMD_CLEAR, 8'($urandom_range(255)));
        n_pat = ($urandom_range(19) == 0) ? $urandom_range(34, 20) : $urandom_range(6);
        repeat (n_pat) send_item(CMD_APPEND, pick_char());
        repeat ($urandom_range(4, 1)) begin
            subj.delete();
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(6)) subj.push_back(pick_char());
            end else begin
                for (int p = 0; p < pat_len; p++) begin
                    if (pat_mem[p] == CH_STAR) begin
                        repeat ($urandom_range(2)) subj.push_back(pick_char());
                    end else if (pat_mem[p] == CH_ANY) begin
                        do c = pick_char(); while (c == CH_DOT);
                        subj.push_back(c);
                    end else begin
                        subj.push_back(pat_mem[p]);
                    end
                end
            end
            foreach (subj[i]) begin
                if ($urandom_range(99) < 4) send_noise();
                send_item(CMD_SUBJECT, subj[i]);
            end
            send_item(CMD_END, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_phase(input int n_items, input int src_pct, input int snk_pct);
        int target;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        target        = sent_count + n_items;
        while (sent_count < target) run_sequence();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data      = '0;
        out_if.ready    = 1'b0;
        pat_len         = '0;
        pat_ovf         = 1'b0;
        foreach (pat_mem[i]) pat_mem[i] = '0;
        live_pos        = fresh_subject();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_literal_symbols();
        test_wildcards();
        test_restart_mid_subject();
        test_pattern_overflow();
        test_random_phase(200, 0, 0);
        test_random_phase(200, 73, 0);
        test_random_phase(200, 0, 73);
        test_random_phase(200, 35, 35);

        in_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
